// ----- hdl/bcdt_pkg.sv -----
// Package for the BCD countdown timer: payload structs, mode codes,
// register indexes and the BCD digit helpers. No dependencies.
`timescale 1ns / 1ps

package bcdt_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_TICKS    = 2'd2;

    localparam logic [7:0]  TICKS_PER_MS_RST  = 8'd31;
    localparam logic [9:0]  MS_PER_SECOND_RST = 10'd1000;
    localparam logic [15:0] BEEP_TICKS_RST    = 16'd1000;

    localparam logic [6:0] BCD_MAX       = 7'h60;
    localparam logic [6:0] BCD_SEC_WRAP  = 7'h59;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_BUTTON = 1'b1
    } req_t;

    typedef struct packed {
        logic req_type;
        logic btn_minute;
        logic btn_second;
        logic btn_start;
    } in_t;

    typedef struct packed {
        logic [6:0] minutes_out;
        logic [6:0] seconds_out;
        logic [1:0] mode_out;
        logic       relay_on;
        logic       buzzer_on;
        logic       time_up;
    } out_t;

    // Adds one to a packed BCD value, holding at 60.
    function automatic logic [6:0] bcd_inc_capped(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v < BCD_MAX) begin
            r = v + 7'd1;
            if (r[3:0] == 4'hA) begin
                r = r + 7'd6;
            end
        end
        return r;
    endfunction

    // Subtracts one from a packed BCD value; x0 borrows to (x-1)9.
    function automatic logic [6:0] bcd_dec(input logic [6:0] v);
        logic [6:0] r;
        if (v[3:0] == 4'h0) begin
            r = v - 7'd7;
        end else begin
            r = v - 7'd1;
        end
        return r;
    endfunction

endpackage

// ----- hdl/bcdt_in_stage.sv -----
// Input register of the BCD countdown timer: holds one accepted item
// until the core consumes it. Depends on bcdt_pkg.
`timescale 1ns / 1ps

module bcdt_in_stage
    import bcdt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic up_valid,
    output logic up_ready,
    input  in_t  up_item,
    output logic dn_valid,
    input  logic dn_ready,
    output in_t  dn_item
);

    logic valid_reg;
    in_t  item_reg;

    // The register frees up in the same cycle its item moves on.
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            item_reg <= up_item;
        end
    end

endmodule

// ----- hdl/bcdt_out_stage.sv -----
// Result register of the BCD countdown timer: holds one result until the
// downstream side takes it. Depends on bcdt_pkg.
`timescale 1ns / 1ps

module bcdt_out_stage
    import bcdt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic up_valid,
    output logic up_ready,
    input  out_t up_res,
    output logic dn_valid,
    input  logic dn_ready,
    output out_t dn_res
);

    logic valid_reg;
    out_t res_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            res_reg <= up_res;
        end
    end

endmodule

// ----- hdl/bcdt_core.sv -----
// Timer state, configuration registers and the single-pass update that
// turns one tick or button sample into one result. Depends on bcdt_pkg.
`timescale 1ns / 1ps

module bcdt_core
    import bcdt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  step,
    input  in_t                   item,
    output out_t                  res
);

    logic [7:0]  tpm_reg;
    logic [9:0]  mps_reg;
    logic [15:0] beep_ticks_reg;

    logic [6:0]  min_reg,      min_next;
    logic [6:0]  sec_reg,      sec_next;
    mode_t       mode_reg,     mode_next;
    logic        counting_reg, counting_next;
    logic        key_reg,      key_next;
    logic        relay_reg,    relay_next;
    logic        buzzer_reg,   buzzer_next;
    logic [15:0] beep_reg,     beep_next;
    logic [7:0]  tick_reg,     tick_next;
    logic [9:0]  ms_reg,       ms_next;

    logic [7:0]  tick_inc;
    logic [9:0]  ms_inc;
    logic        any_key;
    logic        fresh;
    logic        time_up;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg        <= TICKS_PER_MS_RST;
            mps_reg        <= MS_PER_SECOND_RST;
            beep_ticks_reg <= BEEP_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TICKS_PER_MS:  tpm_reg        <= cfg_wdata[7:0];
                CFG_MS_PER_SECOND: mps_reg        <= cfg_wdata[9:0];
                CFG_BEEP_TICKS:    beep_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        min_next      = min_reg;
        sec_next      = sec_reg;
        mode_next     = mode_reg;
        counting_next = counting_reg;
        key_next      = key_reg;
        relay_next    = relay_reg;
        buzzer_next   = buzzer_reg;
        beep_next     = beep_reg;
        tick_next     = tick_reg;
        ms_next       = ms_reg;
        tick_inc      = tick_reg + 8'd1;
        ms_inc        = ms_reg + 10'd1;
        any_key       = item.btn_minute || item.btn_second || item.btn_start;
        fresh         = any_key && !key_reg;
        time_up       = 1'b0;

        if (item.req_type == REQ_TICK) begin
            if (beep_reg != 16'd0) begin
                beep_next = beep_reg - 16'd1;
                if (beep_reg == 16'd1) begin
                    buzzer_next = 1'b0;
                end
            end
            tick_next = tick_inc;
            // A zero prescale compares true on every tick, so it acts as one.
            if (tick_inc >= tpm_reg) begin
                tick_next = 8'd0;
                ms_next   = ms_inc;
                if (ms_inc >= mps_reg) begin
                    ms_next = 10'd0;
                    if (counting_reg && (min_reg != 7'd0 || sec_reg != 7'd0)) begin
                        if (sec_reg == 7'd0) begin
                            sec_next = BCD_SEC_WRAP;
                            min_next = bcd_dec(min_reg);
                        end else begin
                            sec_next = bcd_dec(sec_reg);
                        end
                    end
                end
            end
        end else begin
            if (fresh) begin
                beep_next   = beep_ticks_reg;
                buzzer_next = (beep_ticks_reg != 16'd0);
            end
            case (mode_reg)
                MODE_RUN: begin
                    if (fresh && item.btn_start) begin
                        relay_next    = 1'b0;
                        counting_next = 1'b0;
                        mode_next     = MODE_STOP;
                    end
                end
                MODE_STOP: begin
                    if (fresh && item.btn_start) begin
                        relay_next    = 1'b1;
                        counting_next = 1'b1;
                        mode_next     = MODE_RUN;
                    end
                    // Clearing wins over a resume on the same sample.
                    if (item.btn_minute && item.btn_start) begin
                        min_next      = 7'd0;
                        sec_next      = 7'd0;
                        relay_next    = 1'b0;
                        counting_next = 1'b0;
                        mode_next     = MODE_IDLE;
                    end
                end
                default: begin
                    if (fresh) begin
                        if (item.btn_minute) begin
                            min_next = bcd_inc_capped(min_reg);
                        end
                        if (item.btn_second) begin
                            sec_next = bcd_inc_capped(sec_reg);
                        end
                        if (item.btn_start && (min_next != 7'd0 || sec_next != 7'd0)) begin
                            tick_next     = 8'd0;
                            ms_next       = 10'd0;
                            relay_next    = 1'b1;
                            counting_next = 1'b1;
                            mode_next     = MODE_RUN;
                        end
                    end
                    if (item.btn_minute && item.btn_start) begin
                        min_next = 7'd0;
                        sec_next = 7'd0;
                    end
                end
            endcase
            if (fresh) begin
                key_next = 1'b1;
            end
            if (!any_key) begin
                key_next = 1'b0;
            end
        end

        // A run that sits at zero time ends on this same step.
        if (mode_next == MODE_RUN && min_next == 7'd0 && sec_next == 7'd0) begin
            relay_next    = 1'b0;
            counting_next = 1'b0;
            mode_next     = MODE_IDLE;
            time_up       = 1'b1;
        end

        res.minutes_out = min_next;
        res.seconds_out = sec_next;
        res.mode_out    = mode_next;
        res.relay_on    = relay_next;
        res.buzzer_on   = buzzer_next;
        res.time_up     = time_up;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= 7'd0;
            sec_reg      <= 7'd0;
            mode_reg     <= MODE_IDLE;
            counting_reg <= 1'b0;
            key_reg      <= 1'b0;
            relay_reg    <= 1'b0;
            buzzer_reg   <= 1'b0;
            beep_reg     <= 16'd0;
            tick_reg     <= 8'd0;
            ms_reg       <= 10'd0;
        end else if (step) begin
            min_reg      <= min_next;
            sec_reg      <= sec_next;
            mode_reg     <= mode_next;
            counting_reg <= counting_next;
            key_reg      <= key_next;
            relay_reg    <= relay_next;
            buzzer_reg   <= buzzer_next;
            beep_reg     <= beep_next;
            tick_reg     <= tick_next;
            ms_reg       <= ms_next;
        end
    end

    a_relay_tracks_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (relay_reg == (mode_reg == MODE_RUN)) && (counting_reg == relay_reg))
        else $error("relay or countdown enable out of step with run mode");

    a_run_has_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_RUN) |-> (min_reg != 7'd0 || sec_reg != 7'd0))
        else $error("run mode held with zero time");

    a_buzzer_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        buzzer_reg == (beep_reg != 16'd0))
        else $error("buzzer state disagrees with beep counter");

    a_bcd_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (min_reg[3:0] <= 4'd9) && (sec_reg[3:0] <= 4'd9)
        && (min_reg <= BCD_MAX) && (sec_reg <= BCD_MAX))
        else $error("time register holds an invalid BCD value");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(min_reg) && $stable(sec_reg) && $stable(mode_reg)
                  && $stable(tick_reg) && $stable(ms_reg))
        else $error("timer state changed without a step");

endmodule

// ----- hdl/bcd_countdown_timer.sv -----
// BCD minutes:seconds countdown timer, top level. Instantiates bcdt_in_stage,
// bcdt_core and bcdt_out_stage; depends on bcdt_pkg.
//
// Each input transfer is either one system tick or one sample of the minute,
// second and start buttons, and each produces exactly one result transfer
// carrying the time, mode, relay, buzzer and time-up state after that item.
// The block takes one item per clock cycle while the result side keeps taking
// results (m_ready high); a result is offered on m_valid after its item has
// passed the input register and then the result register, and the state
// update for an item is a single pass of logic in the core between the two.
// Both registers free up in the cycle their contents move on, so a full
// pipeline keeps streaming while m_ready stays high. Configuration writes
// (ticks per millisecond, milliseconds per second, beep length) take effect
// at once and belong in periods when no item is in flight.
`timescale 1ns / 1ps

module bcd_countdown_timer
    import bcdt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_payload
);

    logic item_valid;
    logic item_ready;
    in_t  item;
    out_t res;
    logic step;

    assign step = item_valid && item_ready;

    bcdt_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_item  (s_payload),
        .dn_valid (item_valid),
        .dn_ready (item_ready),
        .dn_item  (item)
    );

    bcdt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .item      (item),
        .res       (res)
    );

    bcdt_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (item_valid),
        .up_ready (item_ready),
        .up_res   (res),
        .dn_valid (m_valid),
        .dn_ready (m_ready),
        .dn_res   (m_payload)
    );

endmodule
